### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### hdl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// Radix digit converter package
// Widths, constants, shared types and the digit-to-character table.
// ----------------------------------------------------------------------------
package rdc_pkg;

   localparam int VALUE_W  = 32;
   localparam int MAG_W    = VALUE_W - 1;
   localparam int DIGIT_W  = 4;
   localparam int CHAR_W   = 7;
   localparam int BASE_W   = 5;

   localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;
   localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
   localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;

   // The division works through a 32-bit word, eight bits per cycle.
   localparam int WORK_W   = 32;
   localparam int CHUNK_W  = 8;
   localparam int CHUNKS   = WORK_W / CHUNK_W;
   localparam int CHUNK_CW = $clog2(CHUNKS);

   // Command queue between the front and the back.
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   localparam logic [CHAR_W-1:0] GLYPHS [16] = '{
      7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55,
      7'd56, 7'd57, 7'd65, 7'd66, 7'd67, 7'd68, 7'd69, 7'd70
   };

   typedef struct packed {
      logic             negative;
      logic [MAG_W-1:0] magnitude;
   } rdc_cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DIVIDE = 5'b00010,
      ST_READ   = 5'b00100,
      ST_EMIT   = 5'b01000,
      ST_ERROR  = 5'b10000
   } rdc_state_type;

   function automatic logic [CHAR_W-1:0] glyph_of(input logic [DIGIT_W-1:0] d);
      return GLYPHS[d];
   endfunction

   // Bases below two act as two, bases above sixteen act as sixteen.
   function automatic logic [BASE_W-1:0] effective_base(input logic [BASE_W-1:0] b);
      logic [BASE_W-1:0] r;
      if (b < BASE_MIN) begin
         r = BASE_MIN;
      end else if (b > BASE_MAX) begin
         r = BASE_MAX;
      end else begin
         r = b;
      end
      return r;
   endfunction

endpackage

### hdl/rdc_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one signed value per item.
// ----------------------------------------------------------------------------
interface rdc_req_if;
   import rdc_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

### hdl/rdc_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one digit item per transfer.
// ----------------------------------------------------------------------------
interface rdc_rsp_if;
   import rdc_pkg::*;

   logic               valid;
   logic               ready;
   logic [DIGIT_W-1:0] digit;
   logic [CHAR_W-1:0]  char_code;
   logic               error;
   logic               last;

   modport source (output valid, output digit, output char_code, output error,
                   output last, input ready);
   modport sink   (input valid, input digit, input char_code, input error,
                   input last, output ready);
endinterface

### hdl/rdc_front.sv
// ----------------------------------------------------------------------------
// Radix digit converter front end
// Accepts request items, splits off the sign and registers the command.
// ----------------------------------------------------------------------------
module rdc_front (
   input  logic                clock,
   input  logic                reset,
   rdc_req_if.sink             req_chan,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output rdc_pkg::rdc_cmd_type cmd
);
   import rdc_pkg::*;

   logic        hold_valid_ff, hold_valid_in;
   rdc_cmd_type hold_cmd_ff, hold_cmd_in;
   logic        take;

   assign req_chan.ready = !hold_valid_ff || cmd_ready;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_cmd_in   = hold_cmd_ff;
      if (take) begin
         hold_valid_in         = 1'b1;
         hold_cmd_in.negative  = req_chan.value[VALUE_W-1];
         hold_cmd_in.magnitude = req_chan.value[MAG_W-1:0];
      end else if (cmd_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_cmd_ff <= hold_cmd_in;
   end

   assign cmd_valid = hold_valid_ff;
   assign cmd       = hold_cmd_ff;

endmodule

### hdl/rdc_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Radix digit converter command queue
// Short first-in first-out queue that decouples the front and back ends.
// ----------------------------------------------------------------------------
module rdc_cmd_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_valid,
   output logic                 wr_ready,
   input  rdc_pkg::rdc_cmd_type wr_cmd,
   output logic                 rd_valid,
   input  logic                 rd_ready,
   output rdc_pkg::rdc_cmd_type rd_cmd
);
   import rdc_pkg::*;

   rdc_cmd_type          entries [FIFO_DEPTH];
   logic [FIFO_PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]   fill_ff, fill_in;
   logic                 push, pop;

   assign wr_ready = (fill_ff != FIFO_CW'(FIFO_DEPTH));
   assign rd_valid = (fill_ff != '0);
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;
   assign rd_cmd   = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + FIFO_PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + FIFO_PW'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FIFO_CW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FIFO_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

### hdl/rdc_back.sv
// ----------------------------------------------------------------------------
// Radix digit converter back end
// Divides by the base eight bits per cycle, stacks the remainders, then
// pops the stack into a registered response.
// ----------------------------------------------------------------------------
module rdc_back #(
   parameter int STACK_DEPTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [rdc_pkg::BASE_W-1:0] base,
   input  logic                       cmd_valid,
   output logic                       cmd_ready,
   input  rdc_pkg::rdc_cmd_type       cmd,
   rdc_rsp_if.source                  rsp_chan
);
   import rdc_pkg::*;

   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   rdc_state_type         state_ff, state_in;
   logic [WORK_W-1:0]     work_ff, work_in;
   logic [DIGIT_W-1:0]    rem_ff, rem_in;
   logic [CHUNK_CW-1:0]   chunk_ff, chunk_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  last_ff, last_in;
   logic [DIGIT_W-1:0]    rd_data_ff;
   logic [DIGIT_W-1:0]    stack_mem [STACK_DEPTH];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DIGIT_W-1:0]    rsp_digit_ff, rsp_digit_in;
   logic [CHAR_W-1:0]     rsp_char_ff, rsp_char_in;
   logic                  rsp_error_ff, rsp_error_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [CHUNK_W-1:0]    qbits;
   logic [DIGIT_W-1:0]    rem_step;
   logic [WORK_W-1:0]     work_step;
   logic [CNT_W-1:0]      count_dec;
   logic                  push_en, rd_en, out_free;

   // Eight steps of restoring division; the remainder stays below the base.
   always_comb begin : div_step
      logic [DIGIT_W:0]   trial;
      logic [DIGIT_W-1:0] r;
      r     = rem_ff;
      qbits = '0;
      for (int i = CHUNK_W - 1; i >= 0; i--) begin
         trial = {r, work_ff[WORK_W - CHUNK_W + i]};
         if (trial >= base) begin
            trial    = trial - base;
            qbits[i] = 1'b1;
         end
         r = trial[DIGIT_W-1:0];
      end
      rem_step = r;
   end

   assign work_step = {work_ff[WORK_W-CHUNK_W-1:0], qbits};
   assign count_dec = count_ff - CNT_W'(1);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign cmd_ready = (state_ff == ST_IDLE);
   assign push_en   = (state_ff == ST_DIVIDE) && (chunk_ff == CHUNK_CW'(CHUNKS - 1))
                      && (count_ff < CNT_W'(STACK_DEPTH));
   assign rd_en     = (state_ff == ST_READ);

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      rem_in       = rem_ff;
      chunk_in     = chunk_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_digit_in = rsp_digit_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_error_in = rsp_error_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.negative) begin
                  state_in = ST_ERROR;
               end else begin
                  state_in = ST_DIVIDE;
                  work_in  = WORK_W'(cmd.magnitude);
                  rem_in   = '0;
                  chunk_in = '0;
                  count_in = '0;
               end
            end
         end
         ST_DIVIDE: begin
            work_in = work_step;
            if (chunk_ff == CHUNK_CW'(CHUNKS - 1)) begin
               if (push_en) begin
                  count_in = count_ff + CNT_W'(1);
               end
               rem_in   = '0;
               chunk_in = '0;
               if (work_step == '0) begin
                  state_in = ST_READ;
               end
            end else begin
               rem_in   = rem_step;
               chunk_in = chunk_ff + CHUNK_CW'(1);
            end
         end
         ST_READ: begin
            count_in = count_dec;
            last_in  = (count_dec == '0);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_digit_in = rd_data_ff;
               rsp_char_in  = glyph_of(rd_data_ff);
               rsp_error_in = 1'b0;
               rsp_last_in  = last_ff;
               state_in     = last_ff ? ST_IDLE : ST_READ;
            end
         end
         ST_ERROR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_digit_in = '0;
               rsp_char_in  = '0;
               rsp_error_in = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         chunk_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chunk_ff     <= chunk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      rem_ff       <= rem_in;
      last_ff      <= last_in;
      rsp_digit_ff <= rsp_digit_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_error_ff <= rsp_error_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Digit stack: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_mem[count_ff[IDX_W-1:0]] <= rem_step;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem[count_dec[IDX_W-1:0]];
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.digit     = rsp_digit_ff;
   assign rsp_chan.char_code = rsp_char_ff;
   assign rsp_chan.error     = rsp_error_ff;
   assign rsp_chan.last      = rsp_last_ff;

endmodule

### hdl/radix_digit_converter.sv
// ----------------------------------------------------------------------------
// Radix digit converter
// Converts signed 32-bit values into digit items in a configurable base.
// ----------------------------------------------------------------------------
// Each request item carries one signed 32-bit value. A non-negative value is
// turned into its digits in the base held in the csr register (reset value
// ten; values below two act as two, values above sixteen act as sixteen),
// and the digits leave the response channel most significant first, one item
// per digit, each with its ASCII character from 0-9 and A-F and with last set
// on the final digit. A value of zero gives the single digit 0. A negative
// value gives one item with error and last set and zero digit and character.
// The back end picks up the command, then divides a 32-bit work word by the
// base eight bits per cycle once per digit, then for each digit reads the
// digit stack and loads the output register. A negative value skips the
// division. The front register and a two-entry command queue take up to
// three further items while the back end is busy, and the output register
// holds a finished item while the next digit is prepared. The digit stack
// needs no clearing after reset. The base may only be written while the
// block is idle.
// ----------------------------------------------------------------------------
module radix_digit_converter #(
   parameter int STACK_DEPTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   rdc_req_if.sink                    req_chan,
   rdc_rsp_if.source                  rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [rdc_pkg::BASE_W-1:0] csr_wr_data
);
   import rdc_pkg::*;

   logic [BASE_W-1:0] base_ff, base_in;
   logic [BASE_W-1:0] base_eff;

   logic        front_valid, front_ready;
   rdc_cmd_type front_cmd;
   logic        queue_valid, queue_ready;
   rdc_cmd_type queue_cmd;

   // Base register; the clamp keeps the divisor between two and sixteen.
   assign base_in  = csr_wr_en ? csr_wr_data : base_ff;
   assign base_eff = effective_base(base_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
      end else begin
         base_ff <= base_in;
      end
   end

   // Front end: takes request items and splits off the sign.
   rdc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   // Command queue lets the front keep accepting while the back divides.
   rdc_cmd_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_ready (front_ready),
      .wr_cmd   (front_cmd),
      .rd_valid (queue_valid),
      .rd_ready (queue_ready),
      .rd_cmd   (queue_cmd)
   );

   // Back end: division, digit stack and response register.
   rdc_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .base      (base_eff),
      .cmd_valid (queue_valid),
      .cmd_ready (queue_ready),
      .cmd       (queue_cmd),
      .rsp_chan  (rsp_chan)
   );

endmodule

### hdl/rdc_checker.sv
// ----------------------------------------------------------------------------
// Radix digit converter checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [rdc_pkg::DIGIT_W-1:0] rsp_digit,
   input logic [rdc_pkg::CHAR_W-1:0]  rsp_char_code,
   input logic                        rsp_error,
   input logic                        rsp_last
);
   import rdc_pkg::*;

   logic [DIGIT_W+CHAR_W+1:0] rsp_payload;
   logic                      rsp_stalled;
   logic                      error_fields_ok;

   assign rsp_payload     = {rsp_digit, rsp_char_code, rsp_error, rsp_last};
   assign rsp_stalled     = rsp_valid && !rsp_ready;
   assign error_fields_ok = rsp_last && (rsp_digit == '0) && (rsp_char_code == '0);

   // A stalled response item holds its payload.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_valid && $stable(rsp_payload))

   // An error item stands alone and carries zero digit and character.
   `ASSERT_IMPLY(a_error_shape, clock, reset, rsp_valid && rsp_error, error_fields_ok)

   // A digit item carries the character of its own digit.
   `ASSERT_IMPLY(a_char_match, clock, reset, rsp_valid && !rsp_error, rsp_char_code == glyph_of(rsp_digit))

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_digit     (rsp_chan.digit),
   .rsp_char_code (rsp_chan.char_code),
   .rsp_error     (rsp_chan.error),
   .rsp_last      (rsp_chan.last)
);
